>>> design/bqf_pkg.sv
package bqf_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } coef_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       clear_history;
    logic                       block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_B0,
    MUL_B1,
    MUL_B2,
    MUL_A1,
    MUL_A2
  } mul_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MB0,
    ST_SUMY,
    ST_ROUND,
    ST_MA1,
    ST_UPD1,
    ST_UPD2,
    ST_OUT
  } bqf_state_t;

  typedef struct packed {
    logic     ld_in;
    mul_sel_t mul_sel;
    logic     ld_acc;
    logic     ld_y;
    logic     ld_t1;
    logic     ld_t2;
    logic     ld_d1;
    logic     ld_d2;
    logic     ld_out;
  } dp_cmd_t;

endpackage

>>> design/biquad_iir_filter.sv
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   in_item_t
// out_      output     out_valid / out_stall out_item_t
// cfg_      input      cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// a request runs through an accept step, six multiply and accumulate
// steps through the single shared multiplier and a step to load the output register
// a request is taken only in idle, so the next one waits until the last is in the output register
// the result waits in the output register while the next request is worked on
// a stall on the output holds only the final step, until the register frees
// synchronous active-low reset: coefficients to b0 = 1.0, others 0, states to 0
module biquad_iir_filter
  import bqf_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0] cfg_wdata
);

  dp_cmd_t cmd;

  assign cfg_ready = 1'b1;

  bqf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bqf_dp #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

>>> design/bqf_ctrl.sv
module bqf_ctrl
  import bqf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  bqf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.mul_sel = MUL_B0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.ld_in = in_valid;
        if (in_valid) state_nxt = ST_MB0;
      end
      ST_MB0: begin
        cmd.mul_sel = MUL_B0;
        state_nxt   = ST_SUMY;
      end
      ST_SUMY: begin
        cmd.mul_sel = MUL_B1;
        cmd.ld_acc  = 1'b1;
        state_nxt   = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.mul_sel = MUL_B2;
        cmd.ld_y    = 1'b1;
        cmd.ld_t1   = 1'b1;
        state_nxt   = ST_MA1;
      end
      ST_MA1: begin
        cmd.mul_sel = MUL_A1;
        cmd.ld_t2   = 1'b1;
        state_nxt   = ST_UPD1;
      end
      ST_UPD1: begin
        cmd.mul_sel = MUL_A2;
        cmd.ld_d1   = 1'b1;
        state_nxt   = ST_UPD2;
      end
      ST_UPD2: begin
        cmd.ld_d2 = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // wait here only while the previous result is still stalled
        if (!out_valid_r || !out_stall) begin
          cmd.ld_out = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.ld_out)       out_valid_nxt = 1'b1;
    else if (!out_stall)  out_valid_nxt = 1'b0;
    else                  out_valid_nxt = out_valid_r;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> design/bqf_dp.sv
module bqf_dp
  import bqf_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_WIDTH-1:0] cfg_wdata,
  output out_item_t             out_data
);

  localparam int STATE_W = SAMPLE_W + COEF_WIDTH;
  localparam int FRAC    = COEF_WIDTH - 4;
  localparam int Q_W     = STATE_W - FRAC;
  localparam int Y_W     = Q_W + 1;

  localparam logic signed [STATE_W-1:0]    ST_MAX  = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0]    ST_MIN  = {1'b1, {(STATE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0]   SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0]   SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0] ONE_Q   = COEF_WIDTH'(1) << FRAC;

  function automatic logic signed [STATE_W-1:0] sat_sum(
    input logic signed [STATE_W-1:0] a,
    input logic signed [STATE_W-1:0] b,
    input logic                      sub
  );
    logic [STATE_W:0] s;
    if (sub) s = {a[STATE_W-1], a} - {b[STATE_W-1], b};
    else     s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
    if (s[STATE_W] != s[STATE_W-1]) return s[STATE_W] ? ST_MIN : ST_MAX;
    return s[STATE_W-1:0];
  endfunction

  logic signed [COEF_WIDTH-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [SAMPLE_W-1:0]   x_r, y_r, y_nxt;
  logic                         be_r;
  logic signed [STATE_W-1:0]    d1_r, d2_r;
  logic signed [STATE_W-1:0]    prod_r, acc_r, t1_r, t2_r;
  logic signed [COEF_WIDTH-1:0] mul_c;
  logic signed [SAMPLE_W-1:0]   mul_s;
  logic signed [STATE_W-1:0]    prod_full;
  logic [Q_W-1:0]               q;
  logic [Y_W-1:0]               yw;
  out_item_t                    out_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= ONE_Q;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      unique case (coef_idx_t'(cfg_index))
        REG_B0:  b0_r <= cfg_wdata;
        REG_B1:  b1_r <= cfg_wdata;
        REG_B2:  b2_r <= cfg_wdata;
        REG_A1:  a1_r <= cfg_wdata;
        REG_A2:  a2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // shared multiplier, coefficient times x or y
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_B0:  begin mul_c = b0_r; mul_s = x_r; end
      MUL_B1:  begin mul_c = b1_r; mul_s = x_r; end
      MUL_B2:  begin mul_c = b2_r; mul_s = x_r; end
      MUL_A1:  begin mul_c = a1_r; mul_s = y_r; end
      MUL_A2:  begin mul_c = a2_r; mul_s = y_r; end
      default: begin mul_c = b0_r; mul_s = x_r; end
    endcase
  end

  assign prod_full = mul_c * mul_s;

  // round half up, then clamp to the sample range
  always_comb begin
    q  = acc_r[STATE_W-1:FRAC];
    yw = {q[Q_W-1], q} + Y_W'(acc_r[FRAC-1]);
    if ((&yw[Y_W-1:SAMPLE_W-1]) || !(|yw[Y_W-1:SAMPLE_W-1]))
      y_nxt = yw[SAMPLE_W-1:0];
    else
      y_nxt = yw[Y_W-1] ? SMP_MIN : SMP_MAX;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_full;
    if (cmd.ld_in) begin
      x_r  <= in_data.sample_in;
      be_r <= in_data.block_end;
    end
    if (cmd.ld_acc) acc_r <= sat_sum(prod_r, d1_r, 1'b0);
    if (cmd.ld_y)   y_r   <= y_nxt;
    if (cmd.ld_t1)  t1_r  <= sat_sum(d2_r, prod_r, 1'b0);
    if (cmd.ld_t2)  t2_r  <= prod_r;
    if (cmd.ld_out) begin
      out_r.sample_out    <= y_r;
      out_r.block_end_out <= be_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r <= '0;
      d2_r <= '0;
    end else begin
      if (cmd.ld_in && in_data.clear_history) begin
        d1_r <= '0;
        d2_r <= '0;
      end
      if (cmd.ld_d1) d1_r <= sat_sum(t1_r, prod_r, 1'b1);
      if (cmd.ld_d2) d2_r <= sat_sum(t2_r, prod_r, 1'b1);
    end
  end

  assign out_data = out_r;

endmodule

>>> design/bqf_checker.sv
module bqf_checker
  import bqf_pkg::*;
#(
  parameter int COEF_WIDTH = 32
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [COEF_WIDTH-1:0] cfg_wdata
);

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous still in work");

  // a fresh result is loaded only as the block returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while block busy");

  // no result appears right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // coefficients must change only while the section is empty; the filter itself does not enforce this
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |->
      (!in_stall && !out_valid && !$isunknown({cfg_index, cfg_wdata})))
    else $error("coefficient write while a request is in flight");

endmodule

bind biquad_iir_filter bqf_checker #(.COEF_WIDTH(COEF_WIDTH)) u_bqf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);
